/* hw/rtl/srt_pkg.sv */
package srt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int ID_W  = 14;
	localparam int KEY_W = 25;
	localparam int PAY_W = 40;
	localparam int ENT_W = KEY_W + PAY_W;
	localparam int RES_W = 7;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_SCAN = 8'b0000_0010,
		ST_CHK  = 8'b0000_0100,
		ST_DEC  = 8'b0000_1000,
		ST_MOVE = 8'b0001_0000,
		ST_MVWR = 8'b0010_0000,
		ST_PUT  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

endpackage

/* hw/rtl/sorted_record_table.sv */
// each command scans the stored records in order from the start, then shifts the records
// that follow its position where needed, before the result is loaded
// throughput: one command at a time, the next is taken the cycle after the result is
// loaded; the sequential scan and shift through the record memory set the pace
// reset: arst_n clears the record count, the sequencer and the result valid flag;
// the record memory is not cleared, only entries below the count are ever read
module sorted_record_table
	import srt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // record_id, arrival_hour, arrival_minute, depart_hour,
	                              // depart_minute, delay_hours, delay_minutes,
	                              // seat_capacity, service_class, zero fill
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status, was_update, removed_count, entry_count
);

	logic [ENT_W-1:0] mem [TABLE_DEPTH];
	logic [ENT_W-1:0] rd_q;

	state_t           state_q;
	logic             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [CNT_W-1:0] n_q, ptr_q, pos_q, first_q, rem_q, i_q;
	logic             upd_q, fail_q;
	logic             m_tvalid_q;
	logic [15:0]      m_tdata_q;

	logic             mem_re, mem_we;
	logic [IDX_W-1:0] mem_raddr, mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic [CNT_W-1:0] im1, idst;
	logic [KEY_W-1:0] rd_key;
	logic [ID_W-1:0]  rd_id, key_id;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign im1    = i_q - 1'b1;
	assign idst   = i_q - rem_q;
	assign rd_key = rd_q[ENT_W-1:PAY_W];
	assign rd_id  = rd_key[KEY_W-1:KEY_W-ID_W];
	assign key_id = key_q[KEY_W-1:KEY_W-ID_W];

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = ptr_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = ptr_q[IDX_W-1:0];
		mem_wdata = rd_q;
		case (state_q)
			ST_SCAN: begin
				mem_re = (ptr_q < n_q);
			end
			ST_CHK: begin
				// key already held: overwrite payload in place
				if (cmd_q == CMD_INSERT && rd_key == key_q) begin
					mem_we    = 1'b1;
					mem_wdata = {key_q, pay_q};
				end
			end
			ST_MOVE: begin
				if (cmd_q == CMD_INSERT) begin
					mem_re    = (i_q > pos_q);
					mem_raddr = im1[IDX_W-1:0];
				end else begin
					mem_re    = (i_q < n_q);
					mem_raddr = i_q[IDX_W-1:0];
				end
			end
			ST_MVWR: begin
				mem_we    = 1'b1;
				mem_waddr = (cmd_q == CMD_INSERT) ? i_q[IDX_W-1:0] : idst[IDX_W-1:0];
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[IDX_W-1:0];
				mem_wdata = {key_q, pay_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						key_q   <= {s_tdata[13:0], s_tdata[18:14], s_tdata[24:19]};
						pay_q   <= s_tdata[64:25];
						ptr_q   <= '0;
						rem_q   <= '0;
						first_q <= '0;
						upd_q   <= 1'b0;
						fail_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ptr_q < n_q) begin
						state_q <= ST_CHK;
					end else begin
						pos_q   <= ptr_q;
						state_q <= ST_DEC;
					end
				end
				ST_CHK: begin
					if (cmd_q == CMD_INSERT) begin
						if (rd_key < key_q) begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= ST_SCAN;
						end else if (rd_key == key_q) begin
							upd_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							pos_q   <= ptr_q;
							state_q <= ST_DEC;
						end
					end else begin
						if (rd_id < key_id) begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= ST_SCAN;
						end else if (rd_id == key_id) begin
							if (rem_q == '0)
								first_q <= ptr_q;
							rem_q   <= rem_q + 1'b1;
							ptr_q   <= ptr_q + 1'b1;
							state_q <= ST_SCAN;
						end else begin
							pos_q   <= ptr_q;
							state_q <= ST_DEC;
						end
					end
				end
				ST_DEC: begin
					if (cmd_q == CMD_INSERT) begin
						if (n_q == CNT_W'(TABLE_DEPTH)) begin
							fail_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							i_q     <= n_q;
							state_q <= ST_MOVE;
						end
					end else begin
						if (rem_q == '0) begin
							fail_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							i_q     <= first_q + rem_q;
							state_q <= ST_MOVE;
						end
					end
				end
				ST_MOVE: begin
					if (cmd_q == CMD_INSERT) begin
						state_q <= (i_q > pos_q) ? ST_MVWR : ST_PUT;
					end else if (i_q < n_q) begin
						state_q <= ST_MVWR;
					end else begin
						n_q     <= n_q - rem_q;
						state_q <= ST_DONE;
					end
				end
				ST_MVWR: begin
					i_q     <= (cmd_q == CMD_INSERT) ? im1 : i_q + 1'b1;
					state_q <= ST_MOVE;
				end
				ST_PUT: begin
					n_q     <= n_q + 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {RES_W'(n_q), RES_W'(rem_q), upd_q, fail_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
